FILE: rtl/distance_vector_route_update_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the distance-vector route update core
// Concurrent property wrappers clocked on the core clock, held off in reset.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_CORE_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_CORE_ASSERT_SVH

// same-cycle implication
`define DVRU_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DVRU_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dvru_pkg.sv
// ----------------------------------------------------------------------------
// dvru_pkg
// Shared types and constants of the distance-vector route update core.
// ----------------------------------------------------------------------------
`default_nettype none

package dvru_pkg;

    // defaults for top-level parameters
    localparam int NODE_COUNT_DEF = 65536;
    localparam int COST_BITS_DEF  = 24;

    // fixed field widths
    localparam int MODE_W     = 2;
    localparam int NODE_W     = 16;
    localparam int IN_COST_W  = 24;
    localparam int OUT_COST_W = 24;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 48;

    localparam logic [NODE_W-1:0] OWN_ID_RESET = 16'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_LINK   = 2'd0,
        MODE_ADVERT = 2'd1,
        MODE_SWEEP  = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    // compare result of the shared cost unit
    typedef struct packed {
        logic gt;   // entry cost above saturated sum
        logic lt;   // entry cost below saturated sum
    } cmp_flags_t;

endpackage

`default_nettype wire

FILE: rtl/distance_vector_route_update_core.sv
// ----------------------------------------------------------------------------
// distance_vector_route_update_core
// Distance-vector routing table with direct links, advertisement merge sweep
// and entry read-back.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tuser: mode; tdata: node, cost, neighbor_id
//  m_*       out  m_tvalid/m_tready  tdata: flags, route fields
//  cfg_*     in   cfg_wr_en          cfg_wr_data: own_id
//
//  Read and end-of-advertisement results can stall on the output; the sweep
//  walks one entry per cycle through the cost unit. Reset and every own_id
//  write clear the tables entry by entry (s_tready low); reset also clears
//  the advert store. Results wait in an output register; a new request is
//  taken meanwhile, only its result stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_vector_route_update_core #(
    parameter int NODE_COUNT = dvru_pkg::NODE_COUNT_DEF,
    parameter int COST_BITS  = dvru_pkg::COST_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // node [15:0], cost [39:16], neighbor_id [55:40]
    input  wire logic [dvru_pkg::S_TDATA_W-1:0] s_tdata,
    // mode [1:0]
    input  wire logic [dvru_pkg::MODE_W-1:0]    s_tuser,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // starter_updated [0], neighbor_needs_update [1], route_valid [2],
    // route_next_hop [18:3], route_cost [42:19]
    output logic      [dvru_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic                           cfg_wr_en,
    input  wire logic [dvru_pkg::NODE_W-1:0]    cfg_wr_data
);

    import dvru_pkg::*;

    `include "distance_vector_route_update_core_assert.svh"

    localparam int NODE_BITS = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam logic [NODE_BITS-1:0] LAST_IDX   = NODE_BITS'(NODE_COUNT - 1);
    localparam logic [NODE_W:0]      NODE_LIMIT = (NODE_W + 1)'(NODE_COUNT);
    localparam logic [COST_BITS-1:0] COST_MAX   = '1;
    localparam logic [31:0]          COST_MAX_W = 32'(COST_MAX);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_PRE,
        S_SWEEP,
        S_REPLY
    } state_t;

    // control registers
    state_t                 state_reg,     state_next;
    logic [NODE_BITS-1:0]   idx_reg,       idx_next;
    logic                   clr_adv_reg,   clr_adv_next;
    logic [NODE_W-1:0]      own_reg,       own_next;
    logic                   upd_self_reg,  upd_self_next;
    logic                   upd_nb_reg,    upd_nb_next;
    logic                   m_tvalid_reg,  m_tvalid_next;

    // payload registers
    mode_t                  mode_reg,      mode_next;
    logic [NODE_W-1:0]      node_reg,      node_next;
    logic [COST_BITS-1:0]   cost_reg,      cost_next;
    logic [NODE_W-1:0]      nb_reg,        nb_next;
    logic [COST_BITS-1:0]   nb_cost_reg,   nb_cost_next;
    logic [COST_BITS-1:0]   adv_own_reg,   adv_own_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg,   m_tdata_next;

    // request fields
    logic [NODE_W-1:0]      in_node;
    logic [IN_COST_W-1:0]   in_cost;
    logic [NODE_W-1:0]      in_nb;
    logic [COST_BITS-1:0]   in_cost_sat;
    logic                   s_accept;

    // index decode
    logic                   node_ok, nb_ok, own_ok;
    logic [NODE_BITS-1:0]   node_idx, nb_idx, own_idx;

    // memory ports
    logic                   hop_we, cost_we, adv_we;
    logic [NODE_BITS-1:0]   hop_waddr, cost_waddr, adv_waddr;
    logic [NODE_W-1:0]      hop_wdata;
    logic [COST_BITS-1:0]   cost_wdata, adv_wdata;
    logic [NODE_BITS-1:0]   hop_raddr, cost_raddr, adv_raddr, sweep_raddr;
    logic [NODE_W-1:0]      hop_rd;
    logic [COST_BITS-1:0]   cost_rd, adv_rd;

    // sweep datapath
    logic [COST_BITS-1:0]   alu_base, alu_sum;
    cmp_flags_t             alu_flags;
    logic                   hop_free, adv_set, take_new, improve, entry_upd;
    logic                   nb_flag, nb_hit;
    logic                   out_load;
    logic [31:0]            cost_wide;
    logic                   rt_valid;
    logic [NODE_W-1:0]      rt_hop;
    logic [OUT_COST_W-1:0]  rt_cost;

    // ------------------------------------------------------------------
    // input unpack, cost clamp to table width
    // ------------------------------------------------------------------
    assign in_node  = s_tdata[15:0];
    assign in_cost  = s_tdata[39:16];
    assign in_nb    = s_tdata[55:40];
    assign in_cost_sat = (32'(in_cost) > COST_MAX_W) ? COST_MAX : COST_BITS'(in_cost);

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign node_ok  = ({1'b0, node_reg} < NODE_LIMIT);
    assign nb_ok    = ({1'b0, nb_reg}   < NODE_LIMIT);
    assign own_ok   = ({1'b0, own_reg}  < NODE_LIMIT);
    assign node_idx = node_reg[NODE_BITS-1:0];
    assign nb_idx   = nb_reg[NODE_BITS-1:0];
    assign own_idx  = own_reg[NODE_BITS-1:0];

    // ------------------------------------------------------------------
    // tables
    // ------------------------------------------------------------------
    dvru_ram #(.DEPTH(NODE_COUNT), .WIDTH(NODE_W), .ADDR_W(NODE_BITS)) u_hop_ram (
        .clk   (aclk),
        .we    (hop_we),
        .waddr (hop_waddr),
        .wdata (hop_wdata),
        .raddr (hop_raddr),
        .rdata (hop_rd)
    );

    dvru_ram #(.DEPTH(NODE_COUNT), .WIDTH(COST_BITS), .ADDR_W(NODE_BITS)) u_cost_ram (
        .clk   (aclk),
        .we    (cost_we),
        .waddr (cost_waddr),
        .wdata (cost_wdata),
        .raddr (cost_raddr),
        .rdata (cost_rd)
    );

    dvru_ram #(.DEPTH(NODE_COUNT), .WIDTH(COST_BITS), .ADDR_W(NODE_BITS)) u_adv_ram (
        .clk   (aclk),
        .we    (adv_we),
        .waddr (adv_waddr),
        .wdata (adv_wdata),
        .raddr (adv_raddr),
        .rdata (adv_rd)
    );

    // ------------------------------------------------------------------
    // shared cost unit: empty entry adds to neighbor's own cost,
    // a held route compares against neighbor's cost to us
    // ------------------------------------------------------------------
    assign hop_free = (hop_rd == '0);
    assign adv_set  = (adv_rd != '0);
    assign alu_base = hop_free ? nb_cost_reg : adv_own_reg;

    dvru_alu #(.COST_BITS(COST_BITS)) u_alu (
        .base_cost  (alu_base),
        .add_cost   (adv_rd),
        .entry_cost (cost_rd),
        .sum_sat    (alu_sum),
        .flags      (alu_flags)
    );

    assign take_new  = hop_free && adv_set;
    assign improve   = !hop_free && adv_set && alu_flags.gt;
    assign entry_upd = take_new || improve;
    assign nb_flag   = !hop_free && (!adv_set || alu_flags.lt);
    // rewrite of the neighbor's own entry feeds later empty entries
    assign nb_hit    = nb_ok && (nb_idx == idx_reg);

    // ------------------------------------------------------------------
    // read addresses
    // ------------------------------------------------------------------
    assign sweep_raddr = (state_reg == S_PRE || idx_reg == LAST_IDX) ?
                         '0 : idx_reg + 1'b1;

    always_comb begin
        hop_raddr  = node_idx;
        cost_raddr = node_idx;
        adv_raddr  = own_idx;
        case (state_reg)
            S_EXEC: begin
                if (mode_reg == MODE_SWEEP) begin
                    cost_raddr = nb_idx;
                end
            end
            S_PRE, S_SWEEP: begin
                hop_raddr  = sweep_raddr;
                cost_raddr = sweep_raddr;
                adv_raddr  = sweep_raddr;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // write ports
    // ------------------------------------------------------------------
    always_comb begin
        hop_we     = 1'b0;
        cost_we    = 1'b0;
        adv_we     = 1'b0;
        hop_waddr  = idx_reg;
        cost_waddr = idx_reg;
        adv_waddr  = idx_reg;
        hop_wdata  = nb_reg;
        cost_wdata = alu_sum;
        adv_wdata  = '0;
        case (state_reg)
            S_CLEAR: begin
                hop_we     = 1'b1;
                cost_we    = 1'b1;
                adv_we     = clr_adv_reg;
                hop_wdata  = (own_ok && own_idx == idx_reg) ? own_reg : '0;
                cost_wdata = '0;
            end
            S_EXEC: begin
                hop_waddr  = node_idx;
                cost_waddr = node_idx;
                adv_waddr  = node_idx;
                hop_wdata  = node_reg;
                cost_wdata = cost_reg;
                adv_wdata  = cost_reg;
                hop_we     = node_ok && (mode_reg == MODE_LINK);
                cost_we    = node_ok && (mode_reg == MODE_LINK);
                adv_we     = node_ok && (mode_reg == MODE_ADVERT);
            end
            S_SWEEP: begin
                hop_we  = entry_upd;
                cost_we = entry_upd;
                adv_we  = 1'b1;     // advert store emptied behind the sweep
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // read result
    // ------------------------------------------------------------------
    assign cost_wide = 32'(cost_rd);
    assign rt_valid  = node_ok && !hop_free;
    assign rt_hop    = node_ok ? hop_rd : '0;
    assign rt_cost   = node_ok ? cost_wide[OUT_COST_W-1:0] : '0;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        clr_adv_next  = clr_adv_reg;
        own_next      = own_reg;
        upd_self_next = upd_self_reg;
        upd_nb_next   = upd_nb_reg;
        mode_next     = mode_reg;
        node_next     = node_reg;
        cost_next     = cost_reg;
        nb_next       = nb_reg;
        nb_cost_next  = nb_cost_reg;
        adv_own_next  = adv_own_reg;
        m_tdata_next  = m_tdata_reg;
        out_load      = 1'b0;

        case (state_reg)
            S_CLEAR: begin
                if (idx_reg == LAST_IDX) begin
                    state_next   = S_IDLE;
                    clr_adv_next = 1'b0;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    mode_next  = mode_t'(s_tuser);
                    node_next  = in_node;
                    cost_next  = in_cost_sat;
                    nb_next    = in_nb;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                case (mode_reg)
                    MODE_SWEEP: begin
                        upd_self_next = 1'b0;
                        upd_nb_next   = 1'b0;
                        state_next    = S_PRE;
                    end
                    MODE_READ: begin
                        state_next = S_REPLY;
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_PRE: begin
                nb_cost_next = nb_ok  ? cost_rd : '0;
                adv_own_next = own_ok ? adv_rd  : '0;
                idx_next     = '0;
                state_next   = S_SWEEP;
            end
            S_SWEEP: begin
                upd_self_next = upd_self_reg | entry_upd;
                upd_nb_next   = upd_nb_reg | nb_flag;
                if (entry_upd && nb_hit) begin
                    nb_cost_next = alu_sum;
                end
                if (idx_reg == LAST_IDX) begin
                    state_next = S_REPLY;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_REPLY: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load = 1'b1;
                    if (mode_reg == MODE_SWEEP) begin
                        m_tdata_next = {{(M_TDATA_W - 2){1'b0}}, upd_nb_reg, upd_self_reg};
                    end else begin
                        m_tdata_next = {{(M_TDATA_W - 43){1'b0}}, rt_cost, rt_hop,
                                        rt_valid, 2'b00};
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // own_id write restarts table init
        if (cfg_wr_en) begin
            own_next   = cfg_wr_data;
            idx_next   = '0;
            state_next = S_CLEAR;
        end

        m_tvalid_next = out_load || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            idx_reg      <= '0;
            clr_adv_reg  <= 1'b1;
            own_reg      <= OWN_ID_RESET;
            upd_self_reg <= 1'b0;
            upd_nb_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            clr_adv_reg  <= clr_adv_next;
            own_reg      <= own_next;
            upd_self_reg <= upd_self_next;
            upd_nb_reg   <= upd_nb_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        mode_reg    <= mode_next;
        node_reg    <= node_next;
        cost_reg    <= cost_next;
        nb_reg      <= nb_next;
        nb_cost_reg <= nb_cost_next;
        adv_own_reg <= adv_own_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `DVRU_ASSERT_NXT(a_sweep_step, aclk, aresetn,
        (state_reg == S_SWEEP) && (idx_reg != LAST_IDX) && !cfg_wr_en,
        idx_reg == $past(idx_reg) + 1'b1, "sweep index did not advance")
    `DVRU_ASSERT_IMP(a_idle_no_write, aclk, aresetn, state_reg == S_IDLE,
        !(hop_we || cost_we || adv_we), "table written while idle")
    `DVRU_ASSERT_IMP(a_out_no_overwrite, aclk, aresetn, out_load,
        !m_tvalid_reg || m_tready, "pending result overwritten")
    `DVRU_ASSERT_IMP(a_result_from_reply, aclk, aresetn, $rose(m_tvalid_reg),
        $past(state_reg == S_REPLY), "result raised outside reply")

endmodule

`default_nettype wire

FILE: rtl/dvru_ram.sv
// ----------------------------------------------------------------------------
// dvru_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dvru_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/dvru_alu.sv
// ----------------------------------------------------------------------------
// dvru_alu
// Shared cost unit: saturating add of two costs and compare against an entry.
// ----------------------------------------------------------------------------
`default_nettype none

module dvru_alu #(
    parameter int COST_BITS = dvru_pkg::COST_BITS_DEF
) (
    input  wire logic [COST_BITS-1:0] base_cost,
    input  wire logic [COST_BITS-1:0] add_cost,
    input  wire logic [COST_BITS-1:0] entry_cost,
    output logic      [COST_BITS-1:0] sum_sat,
    output dvru_pkg::cmp_flags_t      flags
);

    import dvru_pkg::*;

    logic [COST_BITS:0] sum_raw;

    assign sum_raw  = {1'b0, base_cost} + {1'b0, add_cost};
    // clamp at all ones on carry out
    assign sum_sat  = sum_raw[COST_BITS] ? '1 : sum_raw[COST_BITS-1:0];
    assign flags.gt = (entry_cost > sum_sat);
    assign flags.lt = (entry_cost < sum_sat);

endmodule

`default_nettype wire
